>>> design/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared constants, types and the sequence ordering test of the receive
// reorder buffer.
// ----------------------------------------------------------------------------
package rrb_pkg;

  localparam int unsigned DefDepth  = 16;
  localparam int unsigned SeqW      = 15;
  localparam int unsigned LenW      = 11;
  localparam int unsigned TagW      = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned PaddrW    = 3;

  localparam logic [15:0] SeqMod    = 16'd30721;
  localparam logic [14:0] HalfSpace = 15'd15360;
  localparam logic [14:0] FullWin   = 15'd30720;
  localparam logic [15:0] SegBytes  = 16'd1024;
  localparam logic [15:0] WinLimit  = 16'd15;
  localparam logic [14:0] ResetExp  = 15'd1;

  // result kinds
  localparam logic [KindW-1:0] KindDeliver = 2'd0;
  localparam logic [KindW-1:0] KindAck     = 2'd1;
  localparam logic [KindW-1:0] KindFinAck  = 2'd2;

  // register index
  localparam logic RegStartExp = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input item
    logic timeout;   // emit timeout acknowledgement
    logic finish;    // bump expected, emit finish acknowledgement
    logic scan_dec;  // step the scan pointer toward the head
    logic insert;    // insert at the scan pointer
    logic drop;      // mark the packet as dropped on a full buffer
    logic pop;       // release the head entry
    logic ack;       // emit the acknowledgement
  } rrb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_timeout;
    logic is_finish;
    logic accepted;
    logic scan_empty;  // scan pointer has reached the head
    logic scan_dup;
    logic scan_ahead;
    logic full;
    logic head_match;
  } rrb_stat_t;

  // true when s counts as ahead of a, given expected number e
  function automatic logic ahead_of(logic [SeqW-1:0] e, logic [SeqW-1:0] s,
                                    logic [SeqW-1:0] a);
    logic [15:0] sum;
    logic [15:0] wrap;
    logic        res;
    sum  = {1'b0, a} + {1'b0, HalfSpace};
    wrap = (sum >= SeqMod) ? sum - SeqMod : sum;
    res  = 1'b0;
    if (e <= HalfSpace) begin
      res = ({1'b0, s} <= sum) && (s >= a);
    end else begin
      if (((s >= HalfSpace && a >= HalfSpace) || s < HalfSpace) && s > a) begin
        res = 1'b1;
      end
      if (a > HalfSpace && s < HalfSpace && {1'b0, s} <= wrap) begin
        res = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

>>> design/tcp_receive_reorder_buffer.sv
// ----------------------------------------------------------------------------
// tcp_receive_reorder_buffer
// Receive-side reorder buffer: orders packets by sequence number, releases
// the in-order run as tags and acknowledges each item.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  input    | start_i / busy_o      | cmd, seq_number, payload_len, end_flag, tag
//  result   | res_valid_o (strobe)  | kind, out_tag, ack_number, window, ...
//  config   | APB psel/penable/...  | start_expected at address 0
//
//  Timeout and finish items are decided right after capture and end with the
//  result strobe; an accepted packet is scanned from the tail, one entry
//  compared per cycle, then inserted unless a duplicate (dropped when full);
//  the in-order run is then released from the head and an acknowledgement follows.
//  Reset clears the buffer count and loads the expected number with 1.
//  Results are one-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module tcp_receive_reorder_buffer
  import rrb_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cmd_i,
  input  logic [SeqW-1:0]   seq_number_i,
  input  logic [LenW-1:0]   payload_len_i,
  input  logic              end_flag_i,
  input  logic [TagW-1:0]   tag_i,
  output logic              res_valid_o,
  output logic [KindW-1:0]  kind_o,
  output logic [TagW-1:0]   out_tag_o,
  output logic [SeqW-1:0]   ack_number_o,
  output logic [SeqW-1:0]   window_o,
  output logic              retransmit_o,
  output logic              dropped_full_o,
  output logic              last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  rrb_cmd_t        cmd;
  rrb_stat_t       stat;
  logic            cfg_we;
  logic [SeqW-1:0] start_exp;

  // register decode
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == RegStartExp)
                & (paddr[1:0] == 2'b00);
  assign prdata = (paddr[2] == RegStartExp) ? {17'b0, start_exp} : '0;

  rrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  rrb_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (pwdata[SeqW-1:0]),
    .start_exp_o    (start_exp),
    .cmd_bit_i      (cmd_i),
    .seq_number_i   (seq_number_i),
    .payload_len_i  (payload_len_i),
    .end_flag_i     (end_flag_i),
    .tag_i          (tag_i),
    .res_valid_o    (res_valid_o),
    .kind_o         (kind_o),
    .out_tag_o      (out_tag_o),
    .ack_number_o   (ack_number_o),
    .window_o       (window_o),
    .retransmit_o   (retransmit_o),
    .dropped_full_o (dropped_full_o),
    .last_o         (last_o)
  );

endmodule

>>> design/rrb_ctrl.sv
// ----------------------------------------------------------------------------
// rrb_ctrl
// Sequencer of the reorder buffer: decode, tail scan, insertion, release
// of the in-order run, acknowledgement.
// ----------------------------------------------------------------------------
module rrb_ctrl
  import rrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  rrb_stat_t stat_i,
  output rrb_cmd_t  cmd_o,
  output logic      busy_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecide = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StInsert = 3'd3;
  localparam logic [2:0] StRel    = 3'd4;
  localparam logic [2:0] StAck    = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        if (stat_i.is_timeout) begin
          cmd_o.timeout = 1'b1;
          state_d       = StIdle;
        end else if (stat_i.is_finish) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else if (stat_i.accepted) begin
          state_d = StScan;
        end else begin
          state_d = StRel;
        end
      end
      StScan: begin
        if (stat_i.scan_empty) begin
          state_d = StInsert;
        end else if (stat_i.scan_dup) begin
          state_d = StRel;
        end else if (stat_i.scan_ahead) begin
          state_d = StInsert;
        end else begin
          cmd_o.scan_dec = 1'b1;
        end
      end
      StInsert: begin
        if (stat_i.full) begin
          cmd_o.drop = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
        end
        state_d = StRel;
      end
      StRel: begin
        if (stat_i.head_match) begin
          cmd_o.pop = 1'b1;
        end else begin
          state_d = StAck;
        end
      end
      StAck: begin
        cmd_o.ack = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle)
    else $error("load outside idle");
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.timeout, cmd_o.finish, cmd_o.pop, cmd_o.ack}) <= 1)
    else $error("two results in one cycle");
  a_ack_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ack |=> !busy_o)
    else $error("acknowledgement did not end the item");
`endif

endmodule

>>> design/rrb_dp.sv
// ----------------------------------------------------------------------------
// rrb_dp
// Datapath: captured item, expected number, ordered entry row with shift
// insertion and head release, result register.
// ----------------------------------------------------------------------------
module rrb_dp
  import rrb_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrb_cmd_t         cmd_i,
  output rrb_stat_t        stat_o,
  input  logic             cfg_we_i,
  input  logic [SeqW-1:0]  cfg_data_i,
  output logic [SeqW-1:0]  start_exp_o,
  input  logic             cmd_bit_i,
  input  logic [SeqW-1:0]  seq_number_i,
  input  logic [LenW-1:0]  payload_len_i,
  input  logic             end_flag_i,
  input  logic [TagW-1:0]  tag_i,
  output logic             res_valid_o,
  output logic [KindW-1:0] kind_o,
  output logic [TagW-1:0]  out_tag_o,
  output logic [SeqW-1:0]  ack_number_o,
  output logic [SeqW-1:0]  window_o,
  output logic             retransmit_o,
  output logic             dropped_full_o,
  output logic             last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [SeqW-1:0] start_q, exp_q;
  logic [CntW-1:0] count_q, pos_q;
  logic            drop_q;
  logic            l_cmd_q, l_fin_q;
  logic [SeqW-1:0] l_seq_q;
  logic [LenW-1:0] l_len_q;
  logic [TagW-1:0] l_tag_q;

  logic [SeqW-1:0] seq_q  [DEPTH];
  logic [SeqW-1:0] next_q [DEPTH];
  logic [TagW-1:0] tag_q  [DEPTH];

  logic [SeqW-1:0] rd_seq;
  logic [15:0]     next_sum, next_mod;
  logic [SeqW-1:0] exp_bump;
  logic [15:0]     cnt_ext;
  logic [SeqW-1:0] win_cur;

  logic [KindW-1:0] kind_d;
  logic [TagW-1:0]  out_tag_d;
  logic [SeqW-1:0]  ack_number_d;
  logic [SeqW-1:0]  window_d;
  logic             retransmit_d;
  logic             dropped_full_d;
  logic             last_d;

  // scan read, next number, bumped expected, window
  assign rd_seq   = seq_q[IdxW'(pos_q - CntW'(1))];
  assign next_sum = {1'b0, l_seq_q} + 16'(l_len_q);
  assign next_mod = (next_sum >= SeqMod) ? next_sum - SeqMod : next_sum;
  assign exp_bump = (exp_q >= FullWin) ? '0 : exp_q + SeqW'(1);
  assign cnt_ext  = 16'(count_q);
  assign win_cur  = (cnt_ext >= WinLimit) ? '0
                  : SeqW'({1'b0, HalfSpace} - (cnt_ext * SegBytes));

  // status toward the sequencer
  assign stat_o.is_timeout = l_cmd_q;
  assign stat_o.is_finish  = l_fin_q;
  assign stat_o.accepted   = (l_seq_q == exp_q) || ahead_of(exp_q, l_seq_q, exp_q);
  assign stat_o.scan_empty = (pos_q == '0);
  assign stat_o.scan_dup   = (rd_seq == l_seq_q);
  assign stat_o.scan_ahead = ahead_of(exp_q, l_seq_q, rd_seq);
  assign stat_o.full       = (count_q >= CntW'(DEPTH));
  assign stat_o.head_match = (count_q != '0) && (seq_q[0] == exp_q);

  assign start_exp_o = start_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= ResetExp;
      exp_q   <= ResetExp;
      count_q <= '0;
      pos_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
        exp_q   <= cfg_data_i;
      end
      if (cmd_i.load) begin
        pos_q  <= count_q;
        drop_q <= 1'b0;
      end
      if (cmd_i.scan_dec) pos_q <= pos_q - CntW'(1);
      if (cmd_i.drop) drop_q <= 1'b1;
      if (cmd_i.insert) count_q <= count_q + CntW'(1);
      if (cmd_i.pop) begin
        count_q <= count_q - CntW'(1);
        exp_q   <= next_q[0];
      end
      if (cmd_i.finish) exp_q <= exp_bump;
    end
  end

  // capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_cmd_q <= cmd_bit_i;
      l_fin_q <= end_flag_i;
      l_seq_q <= seq_number_i;
      l_len_q <= payload_len_i;
      l_tag_q <= tag_i;
    end
  end

  // entry row: shift up behind the insert point, shift down on release
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.insert) begin
        if (CntW'(i) == pos_q) begin
          seq_q[i]  <= l_seq_q;
          next_q[i] <= next_mod[SeqW-1:0];
          tag_q[i]  <= l_tag_q;
        end else if (i > 0 && CntW'(i) > pos_q) begin
          seq_q[i]  <= seq_q[i-1];
          next_q[i] <= next_q[i-1];
          tag_q[i]  <= tag_q[i-1];
        end
      end else if (cmd_i.pop && i < DEPTH - 1) begin
        seq_q[i]  <= seq_q[i+1];
        next_q[i] <= next_q[i+1];
        tag_q[i]  <= tag_q[i+1];
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.timeout | cmd_i.finish | cmd_i.pop | cmd_i.ack;
    end
  end

  // select the result payload
  always_comb begin
    kind_d         = KindAck;
    out_tag_d      = '0;
    ack_number_d   = exp_q;
    window_d       = win_cur;
    retransmit_d   = 1'b0;
    dropped_full_d = 1'b0;
    last_d         = 1'b1;
    if (cmd_i.timeout) begin
      window_d     = FullWin;
      retransmit_d = 1'b1;
    end else if (cmd_i.finish) begin
      kind_d       = KindFinAck;
      ack_number_d = exp_bump;
      window_d     = HalfSpace;
    end else if (cmd_i.pop) begin
      kind_d       = KindDeliver;
      out_tag_d    = tag_q[0];
      ack_number_d = '0;
      window_d     = '0;
      last_d       = 1'b0;
    end else begin
      dropped_full_d = drop_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    kind_o         <= kind_d;
    out_tag_o      <= out_tag_d;
    ack_number_o   <= ack_number_d;
    window_o       <= window_d;
    retransmit_o   <= retransmit_d;
    dropped_full_o <= dropped_full_d;
    last_o         <= last_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("release from empty buffer");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (count_q < CntW'(DEPTH)) && (pos_q <= count_q))
    else $error("insert without room");
`endif

endmodule

>>> bench/tb_tcp_receive_reorder_buffer.sv
// ----------------------------------------------------------------------------
// tb_tcp_receive_reorder_buffer
// Self-checking bench for the receive reorder buffer. Drives packet, finish
// and timeout commands plus start_expected writes over APB. Each accepted
// command is run through an in-bench predictor of the buffer. Every result
// strobe is compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_tcp_receive_reorder_buffer
  import rrb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Mod      = 30721;
  localparam int unsigned Half     = 15360;
  localparam int unsigned Full     = 30720;
  localparam int unsigned Depth    = DefDepth;
  localparam int unsigned DrainCyc = 2 * DefDepth + 8;
  localparam int unsigned StallMax = 5000;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag;
    logic [SeqW-1:0]  ack;
    logic [SeqW-1:0]  win;
    logic             rtx;
    logic             dfull;
    logic             last;
  } seg_result_t;

  // Predicts the buffer and holds the results still owed by the block
  class reorder_scoreboard;
    int unsigned   exp_seq;
    int unsigned   held;
    int unsigned   q_seq[Depth];
    int unsigned   q_next[Depth];
    int unsigned   q_tag[Depth];
    seg_result_t   owed[$];
    int unsigned   errors;

    function new();
      exp_seq = int'(ResetExp);
      held    = 0;
      errors  = 0;
    endfunction

    function void load_start(int unsigned v);
      exp_seq = v & 32'h7fff;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // s counts as ahead of a, given expected number e
    function bit seq_ahead(int unsigned e, int unsigned s, int unsigned a);
      if (e <= Half) return (s >= a) && (s <= a + Half);
      if (((s >= Half && a >= Half) || s < Half) && s > a) return 1;
      if (a > Half && s < Half && s <= (a + Half) % Mod) return 1;
      return 0;
    endfunction

    function void owe(logic [KindW-1:0] k, int unsigned t, int unsigned a,
                      int unsigned w, bit r, bit d, bit l);
      seg_result_t x;
      x.kind = k; x.tag = TagW'(t); x.ack = SeqW'(a); x.win = SeqW'(w);
      x.rtx = r; x.dfull = d; x.last = l;
      owed = {owed, x};
    endfunction

    // Note an accepted command and queue the results it causes
    function void note_command(bit cmd, int unsigned s, int unsigned len,
                               bit fin, int unsigned tg);
      int unsigned e;
      int          pos;
      int unsigned run;
      bit          dup;
      bit          dropped;
      e       = exp_seq;
      dup     = 0;
      dropped = 0;
      if (cmd) begin
        owe(KindAck, 0, e, Full, 1, 0, 1);
        return;
      end
      if (fin) begin
        exp_seq = (e >= Full) ? 0 : e + 1;
        owe(KindFinAck, 0, exp_seq, Half, 0, 0, 1);
        return;
      end
      // insert in sequence order, scanning from the tail
      if (s == e || seq_ahead(e, s, e)) begin
        pos = int'(held) - 1;
        while (pos >= 0) begin
          if (q_seq[pos] == s) begin
            dup = 1;
            break;
          end
          if (seq_ahead(e, s, q_seq[pos])) break;
          pos--;
        end
        if (!dup) begin
          if (held >= Depth) begin
            dropped = 1;
          end else begin
            for (int i = int'(held); i > pos + 1; i--) begin
              q_seq[i] = q_seq[i-1]; q_next[i] = q_next[i-1]; q_tag[i] = q_tag[i-1];
            end
            q_seq[pos+1]  = s;
            q_next[pos+1] = (s + len) % Mod;
            q_tag[pos+1]  = tg;
            held++;
          end
        end
      end
      // release the contiguous run at the head
      if (held > 0 && q_seq[0] == e) begin
        run = 0;
        while (run + 1 < held && q_next[run] == q_seq[run+1]) run++;
        exp_seq = q_next[run];
        for (int unsigned i = 0; i <= run; i++) owe(KindDeliver, q_tag[i], 0, 0, 0, 0, 0);
        for (int unsigned i = run + 1; i < held; i++) begin
          q_seq[i-run-1] = q_seq[i]; q_next[i-run-1] = q_next[i]; q_tag[i-run-1] = q_tag[i];
        end
        held -= run + 1;
      end
      owe(KindAck, 0, exp_seq, (held >= 15) ? 0 : Half - held * 1024, 0, dropped, 1);
    endfunction

    // Compare one result strobe against the oldest owed result
    function void check_result(seg_result_t got);
      seg_result_t x;
      if (owed.size() == 0) begin
        $error("unexpected result: kind %0d tag %0d ack %0d", got.kind, got.tag, got.ack);
        errors++;
        return;
      end
      x = owed.pop_front();
      if (got.kind !== x.kind) begin
        $error("kind: expected %0d, got %0d", x.kind, got.kind); errors++;
      end
      if (got.tag !== x.tag) begin
        $error("out_tag: expected %0d, got %0d", x.tag, got.tag); errors++;
      end
      if (got.ack !== x.ack) begin
        $error("ack_number: expected %0d, got %0d", x.ack, got.ack); errors++;
      end
      if (got.win !== x.win) begin
        $error("window: expected %0d, got %0d", x.win, got.win); errors++;
      end
      if (got.rtx !== x.rtx) begin
        $error("retransmit: expected %0d, got %0d", x.rtx, got.rtx); errors++;
      end
      if (got.dfull !== x.dfull) begin
        $error("dropped_full: expected %0d, got %0d", x.dfull, got.dfull); errors++;
      end
      if (got.last !== x.last) begin
        $error("last: expected %0d, got %0d", x.last, got.last); errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              cmd_i;
  logic [SeqW-1:0]   seq_number_i;
  logic [LenW-1:0]   payload_len_i;
  logic              end_flag_i;
  logic [TagW-1:0]   tag_i;
  logic              res_valid_o;
  logic [KindW-1:0]  kind_o;
  logic [TagW-1:0]   out_tag_o;
  logic [SeqW-1:0]   ack_number_o;
  logic [SeqW-1:0]   window_o;
  logic              retransmit_o;
  logic              dropped_full_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  reorder_scoreboard sb;
  int unsigned       idle_pct;
  int unsigned       sent;
  int unsigned       stall_cnt;

  tcp_receive_reorder_buffer i_dut (.*);

  // Generate the clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Check each result strobe
  always @(posedge clk_i) begin
    seg_result_t got;
    if (rst_ni && res_valid_o) begin
      got.kind = kind_o; got.tag = out_tag_o; got.ack = ack_number_o;
      got.win = window_o; got.rtx = retransmit_o; got.dfull = dropped_full_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || psel) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallMax) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_cmd(bit cmd, int unsigned s, int unsigned len, bit fin,
                          int unsigned tg);
    start_i       <= 1'b1;
    cmd_i         <= cmd;
    seq_number_i  <= s[SeqW-1:0];
    payload_len_i <= len[LenW-1:0];
    end_flag_i    <= fin;
    tag_i         <= tg[TagW-1:0];
    do @(posedge clk_i); while (busy_o);
    sb.note_command(cmd, s & 32'h7fff, len & 32'h7ff, fin, tg & 32'hff);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_pkt(int unsigned s, int unsigned len, int unsigned tg);
    send_cmd(0, s, len, 0, tg);
  endtask

  // Hold off until every owed result has arrived and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy_o);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  // Write start_expected over APB
  task automatic write_start(int unsigned v);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(RegStartExp) << 2;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.load_start(v);
  endtask

  // Send a shuffled run of segments starting at the expected number
  task automatic send_flow();
    int unsigned base;
    int unsigned len;
    int unsigned n;
    int unsigned j;
    int unsigned t;
    int unsigned segs[$];
    base = sb.exp_seq;
    n    = $urandom_range(1, 18);
    len  = $urandom_range(1, 1024);
    segs = {};
    for (int unsigned k = 0; k < n; k++) segs = {segs, (base + k * len) % Mod};
    if ($urandom_range(0, 3) == 0) segs = {segs, segs[$urandom_range(0, n - 1)]};
    for (int i = segs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = segs[i]; segs[i] = segs[j]; segs[j] = t;
    end
    foreach (segs[i]) send_pkt(segs[i], len, $urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) send_cmd(0, 0, 0, 1, $urandom_range(0, 255));
  endtask

  // Send one arbitrary command, across the whole field ranges or as a packet near the expected number
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0:       send_cmd(1, $urandom_range(0, 32767), $urandom_range(0, 2047),
                        $urandom_range(0, 1), $urandom_range(0, 255));
      1:       send_cmd(0, $urandom_range(0, 32767), $urandom_range(0, 2047), 1,
                        $urandom_range(0, 255));
      2:       send_pkt($urandom_range(0, 32767), $urandom_range(0, 2047),
                        $urandom_range(0, 255));
      default: send_pkt((sb.exp_seq + $urandom_range(0, 20000)) % Mod,
                        $urandom_range(0, 1024), $urandom_range(0, 255));
    endcase
  endtask

  initial begin
    int unsigned goal;
    sb            = new();
    sent          = 0;
    idle_pct      = 0;
    stall_cnt     = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    cmd_i         = 1'b0;
    seq_number_i  = '0;
    payload_len_i = '0;
    end_flag_i    = 1'b0;
    tag_i         = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: timeout, finish and extremes on the reset value
    send_cmd(1, 32767, 2047, 1, 255);
    send_pkt(1, 0, 0);
    send_pkt(1, 2047, 255);
    send_pkt(32767, 1024, 17);
    send_cmd(0, 0, 0, 1, 3);

    // Directed: fill the buffer ahead of a gap, overflow, duplicate, release
    write_start(100);
    for (int unsigned k = 1; k <= 16; k++) send_pkt(100 + k * 10, 10, k);
    send_pkt(100 + 17 * 10, 10, 99);
    send_pkt(130, 10, 77);
    send_pkt(100, 10, 200);

    // Directed: finish at the top of the sequence space
    write_start(Full);
    send_cmd(0, 0, 0, 1, 1);

    // Random phases over several start settings
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_start(0);
        1: write_start(Half + 1);
        default: write_start(Full - 300);
      endcase
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 88 : 0;
      goal = sent + 82;
      while (sent < goal) begin
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_flow();
        if (ph == 0 && sent >= goal - 40 && sent < goal - 30) drain();
        if ($urandom_range(0, 7) == 0) write_start($urandom_range(0, 32767));
      end
      write_start(Half);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
